// File: design/rv32ie_pkg.sv
// ----------------------------------------------------------------------------
// rv32ie_pkg
// Shared types, operation codes and lane helpers for the RV32I execute core.
// ----------------------------------------------------------------------------
`default_nettype none

package rv32ie_pkg;

  localparam int unsigned XLEN   = 32;
  localparam int unsigned OP_W   = 6;
  localparam int unsigned REG_W  = 5;
  localparam int unsigned IMM_W  = 21;
  localparam int unsigned NREGS  = 32;

  // operation codes of the decoded item; unlisted codes behave as OP_NOP
  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 6'd0,  OP_SUB   = 6'd1,  OP_SLT   = 6'd2,  OP_SLTU  = 6'd3,
    OP_AND   = 6'd4,  OP_OR    = 6'd5,  OP_XOR   = 6'd6,  OP_SLL   = 6'd7,
    OP_SRL   = 6'd8,  OP_SRA   = 6'd9,  OP_ADDI  = 6'd10, OP_SLTI  = 6'd11,
    OP_SLTIU = 6'd12, OP_ANDI  = 6'd13, OP_ORI   = 6'd14, OP_XORI  = 6'd15,
    OP_SLLI  = 6'd16, OP_SRLI  = 6'd17, OP_SRAI  = 6'd18, OP_LUI   = 6'd19,
    OP_AUIPC = 6'd20, OP_JAL   = 6'd21, OP_JALR  = 6'd22, OP_BEQ   = 6'd23,
    OP_BNE   = 6'd24, OP_BLT   = 6'd25, OP_BLTU  = 6'd26, OP_BGE   = 6'd27,
    OP_BGEU  = 6'd28, OP_LW    = 6'd29, OP_LH    = 6'd30, OP_LHU   = 6'd31,
    OP_LB    = 6'd32, OP_LBU   = 6'd33, OP_SW    = 6'd34, OP_SH    = 6'd35,
    OP_SB    = 6'd36, OP_NOP   = 6'd37
  } op_e;

  // result of the execute stage
  typedef struct packed {
    logic [XLEN-1:0]  npc;
    logic             wr_en;
    logic [REG_W-1:0] rd;
    logic [XLEN-1:0]  value;
    logic [XLEN-1:0]  addr;
    logic [XLEN-1:0]  sdata;
  } exec_t;

  function automatic logic is_load(input op_e op);
    is_load = (op == OP_LW) || (op == OP_LH) || (op == OP_LHU) ||
              (op == OP_LB) || (op == OP_LBU);
  endfunction

  function automatic logic is_store(input op_e op);
    is_store = (op == OP_SW) || (op == OP_SH) || (op == OP_SB);
  endfunction

  // pick the lane of a loaded word and extend it
  function automatic logic [XLEN-1:0] load_extract(input op_e op, input logic [1:0] lane,
                                                   input logic [XLEN-1:0] word);
    logic [15:0] half;
    logic [7:0]  byte_v;
    half = lane[1] ? word[31:16] : word[15:0];
    case (lane)
      2'd0:    byte_v = word[7:0];
      2'd1:    byte_v = word[15:8];
      2'd2:    byte_v = word[23:16];
      default: byte_v = word[31:24];
    endcase
    case (op)
      OP_LH:   load_extract = {{16{half[15]}}, half};
      OP_LHU:  load_extract = {16'h0000, half};
      OP_LB:   load_extract = {{24{byte_v[7]}}, byte_v};
      OP_LBU:  load_extract = {24'h000000, byte_v};
      default: load_extract = word;
    endcase
  endfunction

  // merge store data into the old word at its lane
  function automatic logic [XLEN-1:0] store_merge(input op_e op, input logic [1:0] lane,
                                                  input logic [XLEN-1:0] word,
                                                  input logic [XLEN-1:0] data);
    logic [XLEN-1:0] merged;
    merged = word;
    case (op)
      OP_SH: begin
        if (lane[1]) begin
          merged[31:16] = data[15:0];
        end else begin
          merged[15:0] = data[15:0];
        end
      end
      OP_SB: begin
        case (lane)
          2'd0:    merged[7:0]   = data[7:0];
          2'd1:    merged[15:8]  = data[7:0];
          2'd2:    merged[23:16] = data[7:0];
          default: merged[31:24] = data[7:0];
        endcase
      end
      default: merged = data;
    endcase
    store_merge = merged;
  endfunction

endpackage

`default_nettype wire

// File: design/rv32ie_if.sv
// ----------------------------------------------------------------------------
// rv32ie_if
// Valid/ready channels carrying decoded instructions in and results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rv32ie_issue_if;
  import rv32ie_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [REG_W-1:0] dest_reg;
  logic [REG_W-1:0] src_reg_a;
  logic [REG_W-1:0] src_reg_b;
  logic [IMM_W-1:0] immediate;

  modport source (
    output valid, operation, dest_reg, src_reg_a, src_reg_b, immediate,
    input  ready
  );
  modport sink (
    input  valid, operation, dest_reg, src_reg_a, src_reg_b, immediate,
    output ready
  );
endinterface

interface rv32ie_result_if;
  import rv32ie_pkg::*;

  logic             valid;
  logic             ready;
  logic [XLEN-1:0]  next_pc;
  logic             reg_written;
  logic [REG_W-1:0] written_index;
  logic [XLEN-1:0]  written_value;
  logic [XLEN-1:0]  mem_address;

  modport source (
    output valid, next_pc, reg_written, written_index, written_value, mem_address,
    input  ready
  );
  modport sink (
    input  valid, next_pc, reg_written, written_index, written_value, mem_address,
    output ready
  );
endinterface

`default_nettype wire

// File: design/rv32ie_exec.sv
// ----------------------------------------------------------------------------
// rv32ie_exec
// Combinational execute: ALU, shifts, upper immediates, jumps, branches and
// effective address generation for one instruction.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32ie_exec (
  input  rv32ie_pkg::op_e                    op_i,
  input  logic [rv32ie_pkg::REG_W-1:0]       rd_i,
  input  logic [rv32ie_pkg::XLEN-1:0]        a_i,
  input  logic [rv32ie_pkg::XLEN-1:0]        b_i,
  input  logic [rv32ie_pkg::IMM_W-1:0]       imm_i,
  input  logic [rv32ie_pkg::XLEN-1:0]        pc_i,
  output rv32ie_pkg::exec_t                  res_o
);
  import rv32ie_pkg::*;

  logic [XLEN-1:0] i_imm;
  logic [XLEN-1:0] b_imm;
  logic [XLEN-1:0] j_imm;
  logic [XLEN-1:0] u_imm;
  logic [XLEN-1:0] a_plus_i;
  logic [XLEN-1:0] pc_plus4;
  logic [XLEN-1:0] val;
  logic [XLEN-1:0] addr;
  logic [XLEN-1:0] npc;
  logic            wr;
  logic            taken;

  // immediate formats
  assign i_imm    = {{20{imm_i[11]}}, imm_i[11:0]};
  assign b_imm    = {{19{imm_i[12]}}, imm_i[12:1], 1'b0};
  assign j_imm    = {{11{imm_i[20]}}, imm_i[20:1], 1'b0};
  assign u_imm    = {imm_i[19:0], 12'h000};
  assign a_plus_i = a_i + i_imm;
  assign pc_plus4 = pc_i + 32'd4;

  // operation decode and datapath
  always_comb begin
    wr    = 1'b0;
    val   = '0;
    addr  = '0;
    taken = 1'b0;
    npc   = pc_plus4;
    case (op_i)
      OP_ADD:   begin wr = 1'b1; val = a_i + b_i; end
      OP_SUB:   begin wr = 1'b1; val = a_i - b_i; end
      OP_SLT:   begin wr = 1'b1; val = {31'd0, $signed(a_i) < $signed(b_i)}; end
      OP_SLTU:  begin wr = 1'b1; val = {31'd0, a_i < b_i}; end
      OP_AND:   begin wr = 1'b1; val = a_i & b_i; end
      OP_OR:    begin wr = 1'b1; val = a_i | b_i; end
      OP_XOR:   begin wr = 1'b1; val = a_i ^ b_i; end
      OP_SLL:   begin wr = 1'b1; val = a_i << b_i[4:0]; end
      OP_SRL:   begin wr = 1'b1; val = a_i >> b_i[4:0]; end
      OP_SRA:   begin wr = 1'b1; val = $unsigned($signed(a_i) >>> b_i[4:0]); end
      OP_ADDI:  begin wr = 1'b1; val = a_plus_i; end
      OP_SLTI:  begin wr = 1'b1; val = {31'd0, $signed(a_i) < $signed(i_imm)}; end
      OP_SLTIU: begin wr = 1'b1; val = {31'd0, a_i < i_imm}; end
      OP_ANDI:  begin wr = 1'b1; val = a_i & i_imm; end
      OP_ORI:   begin wr = 1'b1; val = a_i | i_imm; end
      OP_XORI:  begin wr = 1'b1; val = a_i ^ i_imm; end
      OP_SLLI:  begin wr = 1'b1; val = a_i << imm_i[4:0]; end
      OP_SRLI:  begin wr = 1'b1; val = a_i >> imm_i[4:0]; end
      OP_SRAI:  begin wr = 1'b1; val = $unsigned($signed(a_i) >>> imm_i[4:0]); end
      OP_LUI:   begin wr = 1'b1; val = u_imm; end
      OP_AUIPC: begin wr = 1'b1; val = pc_i + u_imm; end
      OP_JAL:   begin wr = 1'b1; val = pc_plus4; npc = pc_i + j_imm; end
      OP_JALR:  begin wr = 1'b1; val = pc_plus4; npc = {a_plus_i[31:1], 1'b0}; end
      OP_BEQ:   taken = (a_i == b_i);
      OP_BNE:   taken = (a_i != b_i);
      OP_BLT:   taken = ($signed(a_i) < $signed(b_i));
      OP_BLTU:  taken = (a_i < b_i);
      OP_BGE:   taken = ($signed(a_i) >= $signed(b_i));
      OP_BGEU:  taken = (a_i >= b_i);
      OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU: begin
        wr   = 1'b1;
        addr = a_plus_i;
      end
      OP_SW, OP_SH, OP_SB: addr = a_plus_i;
      default:  wr = 1'b0;
    endcase
    if (taken) begin
      npc = pc_i + b_imm;
    end
  end

  // writes to x0 are dropped and reported as no write
  always_comb begin
    res_o       = '0;
    res_o.npc   = npc;
    res_o.wr_en = wr && (rd_i != '0);
    res_o.rd    = res_o.wr_en ? rd_i : '0;
    res_o.value = res_o.wr_en ? val : '0;
    res_o.addr  = addr;
    res_o.sdata = b_i;
  end

endmodule

`default_nettype wire

// File: design/rv32ie_regfile.sv
// ----------------------------------------------------------------------------
// rv32ie_regfile
// 32-entry register file, two registered read ports, one write port, per-entry
// valid bits for the zero reset and a bypass of the most recent write.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32ie_regfile (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [rv32ie_pkg::REG_W-1:0]  ra_addr_i,
  input  logic [rv32ie_pkg::REG_W-1:0]  rb_addr_i,
  output logic [rv32ie_pkg::XLEN-1:0]   ra_data_o,
  output logic [rv32ie_pkg::XLEN-1:0]   rb_data_o,
  input  logic                          we_i,
  input  logic [rv32ie_pkg::REG_W-1:0]  waddr_i,
  input  logic [rv32ie_pkg::XLEN-1:0]   wdata_i
);
  import rv32ie_pkg::*;

  logic [XLEN-1:0]  mem_q [NREGS];
  logic [NREGS-1:0] valid_q;
  logic [XLEN-1:0]  ra_rdata_q;
  logic [XLEN-1:0]  rb_rdata_q;
  logic [REG_W-1:0] ra_addr_q;
  logic [REG_W-1:0] rb_addr_q;
  logic             wb_valid_q;
  logic [REG_W-1:0] wb_idx_q;
  logic [XLEN-1:0]  wb_data_q;

  // storage and registered reads; an entry never written reads as zero
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    ra_rdata_q <= valid_q[ra_addr_i] ? mem_q[ra_addr_i] : '0;
    rb_rdata_q <= valid_q[rb_addr_i] ? mem_q[rb_addr_i] : '0;
    ra_addr_q  <= ra_addr_i;
    rb_addr_q  <= rb_addr_i;
    if (we_i) begin
      wb_idx_q  <= waddr_i;
      wb_data_q <= wdata_i;
    end
  end

  // valid bits and last-write flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      wb_valid_q <= 1'b0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
      wb_valid_q       <= 1'b1;
    end
  end

  // a write at the read edge is not in the read data yet
  assign ra_data_o = (wb_valid_q && (wb_idx_q == ra_addr_q)) ? wb_data_q : ra_rdata_q;
  assign rb_data_o = (wb_valid_q && (wb_idx_q == rb_addr_q)) ? wb_data_q : rb_rdata_q;

endmodule

`default_nettype wire

// File: design/rv32ie_dmem.sv
// ----------------------------------------------------------------------------
// rv32ie_dmem
// Word-organised data memory: one registered read port, one write port and
// a bypass of the most recent write.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32ie_dmem #(
  parameter int unsigned MEM_WORDS = 4096,
  localparam int unsigned AW = $clog2(MEM_WORDS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [AW-1:0]                rd_idx_i,
  output logic [rv32ie_pkg::XLEN-1:0]  rd_word_o,
  input  logic                         wr_en_i,
  input  logic [AW-1:0]                wr_idx_i,
  input  logic [rv32ie_pkg::XLEN-1:0]  wr_data_i
);
  import rv32ie_pkg::*;

  logic [XLEN-1:0] mem_q [MEM_WORDS];
  logic [XLEN-1:0] rdata_q;
  logic [AW-1:0]   rd_idx_q;
  logic            lw_valid_q;
  logic [AW-1:0]   lw_idx_q;
  logic [XLEN-1:0] lw_data_q;

  // memory array with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
      lw_idx_q        <= wr_idx_i;
      lw_data_q       <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q  <= mem_q[rd_idx_i];
      rd_idx_q <= rd_idx_i;
    end
  end

  // last-write flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_valid_q <= 1'b0;
    end else if (wr_en_i) begin
      lw_valid_q <= 1'b1;
    end
  end

  // a write at the read edge overrides the old read data
  assign rd_word_o = (lw_valid_q && (lw_idx_q == rd_idx_q)) ? lw_data_q : rdata_q;

endmodule

`default_nettype wire

// File: design/rv32i_integer_execute_core.sv
// ----------------------------------------------------------------------------
// rv32i_integer_execute_core
// Executes one decoded RV32I instruction per item against its own register
// file, program counter and data memory.
//
// issue_i carries decoded instructions (operation, rd, rs1, rs2, raw
// immediate); result_o returns one item per instruction: next PC, the
// register write and the load/store address. Both are valid/ready.
// Pipeline: issue register (register file read), execute register (ALU,
// branch, address, data memory read), result register (load lane select,
// store merge, register and memory write-back). Operands are bypassed from
// the write-back stage, so dependent instructions follow back to back.
// A result is valid once its item has moved through the issue and execute registers into the result register.
// Throughput: one item per cycle while result_o is not stalled; the register
// file read and the single data memory read port each take one access per item.
// Reset clears the PC and the register file (per-entry valid bits) at once;
// the data memory is not cleared and needs no clearing pass.
// When result_o stalls, the result register holds and the stages behind it
// keep filling, so up to three items stay in flight before issue_i.ready
// drops. MEM_WORDS must be a power of two (the block does not check it); the
// word index is address bits above the byte offset modulo MEM_WORDS.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32i_integer_execute_core #(
  parameter int unsigned MEM_WORDS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rv32ie_issue_if.sink      issue_i,
  rv32ie_result_if.source   result_o
);
  import rv32ie_pkg::*;

  localparam int unsigned AW = $clog2(MEM_WORDS);

  // handshake
  logic             s1_valid_q;
  logic             s2_valid_q;
  logic             out_valid_q;
  logic             s1_adv;
  logic             s2_adv;
  logic             s1_free;
  logic             s2_free;
  logic             in_acc;

  // issue stage
  op_e              s1_op_q;
  logic [REG_W-1:0] s1_rd_q;
  logic [REG_W-1:0] s1_ra_q;
  logic [REG_W-1:0] s1_rb_q;
  logic [IMM_W-1:0] s1_imm_q;
  logic [XLEN-1:0]  pc_q;

  // execute stage
  op_e              s2_op_q;
  logic             s2_wr_q;
  logic [REG_W-1:0] s2_rd_q;
  logic [XLEN-1:0]  s2_val_q;
  logic [XLEN-1:0]  s2_npc_q;
  logic [XLEN-1:0]  s2_addr_q;
  logic [XLEN-1:0]  s2_sdata_q;
  logic [XLEN-1:0]  s2_result;
  logic [XLEN-1:0]  s2_store_word;

  // result register
  logic [XLEN-1:0]  out_npc_q;
  logic             out_wr_q;
  logic [REG_W-1:0] out_rd_q;
  logic [XLEN-1:0]  out_val_q;
  logic [XLEN-1:0]  out_addr_q;

  logic [REG_W-1:0] rf_ra_addr;
  logic [REG_W-1:0] rf_rb_addr;
  logic [XLEN-1:0]  rf_a;
  logic [XLEN-1:0]  rf_b;
  logic [XLEN-1:0]  op_a;
  logic [XLEN-1:0]  op_b;
  logic [XLEN-1:0]  dm_word;
  exec_t            ex;

  // pipeline advance
  assign s2_adv  = s2_valid_q && (!out_valid_q || result_o.ready);
  assign s2_free = !s2_valid_q || s2_adv;
  assign s1_adv  = s1_valid_q && s2_free;
  assign s1_free = !s1_valid_q || s1_adv;
  assign in_acc  = issue_i.valid && s1_free;
  assign issue_i.ready = s1_free;

  // register file reads follow the item that will sit in the issue stage
  assign rf_ra_addr = s1_free ? issue_i.src_reg_a : s1_ra_q;
  assign rf_rb_addr = s1_free ? issue_i.src_reg_b : s1_rb_q;

  rv32ie_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ra_addr_i (rf_ra_addr),
    .rb_addr_i (rf_rb_addr),
    .ra_data_o (rf_a),
    .rb_data_o (rf_b),
    .we_i      (s2_adv && s2_wr_q),
    .waddr_i   (s2_rd_q),
    .wdata_i   (s2_result)
  );

  // bypass from the instruction still in the execute stage
  assign op_a = (s2_valid_q && s2_wr_q && (s2_rd_q == s1_ra_q)) ? s2_result : rf_a;
  assign op_b = (s2_valid_q && s2_wr_q && (s2_rd_q == s1_rb_q)) ? s2_result : rf_b;

  rv32ie_exec u_exec (
    .op_i  (s1_op_q),
    .rd_i  (s1_rd_q),
    .a_i   (op_a),
    .b_i   (op_b),
    .imm_i (s1_imm_q),
    .pc_i  (pc_q),
    .res_o (ex)
  );

  rv32ie_dmem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (s1_adv),
    .rd_idx_i  (ex.addr[2 +: AW]),
    .rd_word_o (dm_word),
    .wr_en_i   (s2_adv && is_store(s2_op_q)),
    .wr_idx_i  (s2_addr_q[2 +: AW]),
    .wr_data_i (s2_store_word)
  );

  // load lane select and store merge
  assign s2_result     = is_load(s2_op_q) ? load_extract(s2_op_q, s2_addr_q[1:0], dm_word)
                                          : s2_val_q;
  assign s2_store_word = store_merge(s2_op_q, s2_addr_q[1:0], dm_word, s2_sdata_q);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= issue_i.valid;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (!out_valid_q || result_o.ready) begin
        out_valid_q <= s2_valid_q;
      end
      if (s1_adv) begin
        pc_q <= ex.npc;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q  <= op_e'(issue_i.operation);
      s1_rd_q  <= issue_i.dest_reg;
      s1_ra_q  <= issue_i.src_reg_a;
      s1_rb_q  <= issue_i.src_reg_b;
      s1_imm_q <= issue_i.immediate;
    end
    if (s1_adv) begin
      s2_op_q    <= s1_op_q;
      s2_wr_q    <= ex.wr_en;
      s2_rd_q    <= ex.rd;
      s2_val_q   <= ex.value;
      s2_npc_q   <= ex.npc;
      s2_addr_q  <= ex.addr;
      s2_sdata_q <= ex.sdata;
    end
    if (s2_adv) begin
      out_npc_q  <= s2_npc_q;
      out_wr_q   <= s2_wr_q;
      out_rd_q   <= s2_rd_q;
      out_val_q  <= s2_wr_q ? s2_result : '0;
      out_addr_q <= s2_addr_q;
    end
  end

  // result channel
  assign result_o.valid         = out_valid_q;
  assign result_o.next_pc       = out_npc_q;
  assign result_o.reg_written   = out_wr_q;
  assign result_o.written_index = out_rd_q;
  assign result_o.written_value = out_val_q;
  assign result_o.mem_address   = out_addr_q;

endmodule

`default_nettype wire

// File: design/rv32ie_checker.sv
// ----------------------------------------------------------------------------
// rv32ie_checker
// Port-level checks for the RV32I execute core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32ie_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          reg_written_i,
  input logic [rv32ie_pkg::REG_W-1:0]  written_index_i,
  input logic [rv32ie_pkg::XLEN-1:0]   written_value_i,
  input logic [rv32ie_pkg::XLEN-1:0]   next_pc_i
);
  import rv32ie_pkg::*;

  // an empty result register means the pipeline can take an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("issue stalled with an empty result register");

  // no write reports no index and no value, a write never targets x0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (reg_written_i ? (written_index_i != '0)
                                   : ((written_index_i == '0) && (written_value_i == '0))))
    else $error("inconsistent register write report");

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // a stalled result holds its next PC and written value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(next_pc_i) && $stable(written_value_i))
    else $error("result payload changed while stalled");

endmodule

bind rv32i_integer_execute_core rv32ie_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (issue_i.ready),
  .out_valid_i     (result_o.valid),
  .out_ready_i     (result_o.ready),
  .reg_written_i   (result_o.reg_written),
  .written_index_i (result_o.written_index),
  .written_value_i (result_o.written_value),
  .next_pc_i       (result_o.next_pc)
);

`default_nettype wire
